[rtl/smx_pkg.sv]
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, widths and constants of the softmax / entropy classifier.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int CLS_W       = 2;

  // log2(e) in Q1.16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // fraction bits of the base-2 exponent, one multiply each
  localparam int POW_STEPS = 8;

  // exponent sum and long division
  localparam int SUM_W   = 17 + $clog2(NUM_CLASSES);
  localparam int QUO_W   = 17;
  localparam int DIV_PER = 3;
  localparam int DIV_STG = (QUO_W + DIV_PER - 1) / DIV_PER;

  // log2 fraction bits, one squaring each
  localparam int LOG_STEPS = 16;
  localparam int TERM_W    = 37;
  localparam int TSUM_W    = TERM_W + $clog2(NUM_CLASSES);

  localparam logic [15:0] MIN_GREEN_RST   = 16'd3277;
  localparam logic [15:0] MAX_ENTROPY_RST = 16'd24576;
  localparam logic [15:0] MIN_CONF_RST    = 16'd32768;

  typedef logic signed [15:0] logit_t;
  typedef logic [15:0]        q16_t;
  typedef logic [16:0]        exp_t;

  typedef enum logic [1:0] {
    CFG_MIN_GREEN   = 2'd0,
    CFG_MAX_ENTROPY = 2'd1,
    CFG_MIN_CONF    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    q16_t min_green;
    q16_t max_entropy;
    q16_t min_conf;
  } thr_t;

  // 2^(-2^-(k+1)) in Q0.16
  function automatic logic [15:0] pow2_neg(input logic [2:0] k);
    logic [15:0] v;
    unique case (k)
      3'd0: v = 16'd46341;
      3'd1: v = 16'd55109;
      3'd2: v = 16'd60097;
      3'd3: v = 16'd62757;
      3'd4: v = 16'd64132;
      3'd5: v = 16'd64830;
      3'd6: v = 16'd65182;
      3'd7: v = 16'd65359;
      default: v = 16'd65359;
    endcase
    return v;
  endfunction

endpackage

[rtl/smx_exp.sv]
// ----------------------------------------------------------------------------
// smx_exp
// Max subtraction and base-2 exponential of each logit gap, at most one
// multiply per stage.
// ----------------------------------------------------------------------------
module smx_exp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  smx_pkg::logit_t logit [smx_pkg::NUM_CLASSES],
  input  smx_pkg::q16_t   green_in,
  output logic            vld_out,
  output smx_pkg::exp_t   e_out [smx_pkg::NUM_CLASSES],
  output smx_pkg::q16_t   green_out
);
  import smx_pkg::*;

  // gap, scale, fraction multiplies, final shift
  localparam int NSTG = POW_STEPS + 3;

  logic               vld_r   [NSTG];
  q16_t               green_r [NSTG];
  logic [15:0]        d_r     [NUM_CLASSES];
  logic [15:0]        d_nxt   [NUM_CLASSES];
  exp_t               m_r     [POW_STEPS+1][NUM_CLASSES];
  exp_t               m_nxt   [POW_STEPS+1][NUM_CLASSES];
  logic [8:0]         n_r     [POW_STEPS+1][NUM_CLASSES];
  logic [8:0]         n_nxt   [POW_STEPS+1][NUM_CLASSES];
  logic [7:0]         f_r     [POW_STEPS+1][NUM_CLASSES];
  logic [7:0]         f_nxt   [POW_STEPS+1][NUM_CLASSES];
  exp_t               e_r     [NUM_CLASSES];
  exp_t               e_nxt   [NUM_CLASSES];
  logit_t             mx;
  logic signed [16:0] diff    [NUM_CLASSES];
  logic [33:0]        yprod   [NUM_CLASSES];
  logic [32:0]        mprod   [POW_STEPS][NUM_CLASSES];

  always_comb begin
    mx = logit[0];
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (logit[i] > mx) mx = logit[i];
    end
    for (int i = 0; i < NUM_CLASSES; i++) begin
      diff[i]  = {mx[15], mx} - {logit[i][15], logit[i]};
      d_nxt[i] = diff[i][15:0];
    end

    // gap times log2(e): integer part and 8 fraction bits
    for (int i = 0; i < NUM_CLASSES; i++) begin
      yprod[i]    = 34'(d_r[i]) * 34'(LOG2E_Q16);
      m_nxt[0][i] = 17'h10000;
      n_nxt[0][i] = yprod[i][32:24];
      f_nxt[0][i] = yprod[i][23:16];
    end

    for (int k = 0; k < POW_STEPS; k++) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        mprod[k][i]   = 33'(m_r[k][i]) * 33'(pow2_neg(3'(k))) + 33'd32768;
        m_nxt[k+1][i] = f_r[k][i][POW_STEPS-1-k] ? mprod[k][i][32:16] : m_r[k][i];
        n_nxt[k+1][i] = n_r[k][i];
        f_nxt[k+1][i] = f_r[k][i];
      end
    end

    for (int i = 0; i < NUM_CLASSES; i++) begin
      e_nxt[i] = (n_r[POW_STEPS][i] >= 9'd17) ? '0
               : (m_r[POW_STEPS][i] >> n_r[POW_STEPS][i][4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
      for (int s = 1; s < NSTG; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      green_r[0] <= green_in;
      for (int s = 1; s < NSTG; s++) green_r[s] <= green_r[s-1];
      d_r <= d_nxt;
      m_r <= m_nxt;
      n_r <= n_nxt;
      f_r <= f_nxt;
      e_r <= e_nxt;
    end
  end

  assign vld_out   = vld_r[NSTG-1];
  assign e_out     = e_r;
  assign green_out = green_r[NSTG-1];

endmodule

[rtl/smx_div.sv]
// ----------------------------------------------------------------------------
// smx_div
// Exponent sum and rounded normalisation by restoring long division,
// a few quotient bits per stage in every lane.
// ----------------------------------------------------------------------------
module smx_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  smx_pkg::exp_t e_in [smx_pkg::NUM_CLASSES],
  input  smx_pkg::q16_t green_in,
  output logic          vld_out,
  output smx_pkg::q16_t prob_out [smx_pkg::NUM_CLASSES],
  output smx_pkg::q16_t green_out
);
  import smx_pkg::*;

  localparam int NSTG = DIV_STG + 1;

  logic             vld_r   [NSTG];
  q16_t             green_r [NSTG];
  logic [SUM_W-1:0] sum_r   [NSTG];
  logic [SUM_W-1:0] sum_nxt [NSTG];
  logic [SUM_W-1:0] rem_r   [NSTG][NUM_CLASSES];
  logic [SUM_W-1:0] rem_nxt [NSTG][NUM_CLASSES];
  logic [QUO_W-1:0] lo_r    [NSTG][NUM_CLASSES];
  logic [QUO_W-1:0] lo_nxt  [NSTG][NUM_CLASSES];
  logic [QUO_W-1:0] q_r     [NSTG][NUM_CLASSES];
  logic [QUO_W-1:0] q_nxt   [NSTG][NUM_CLASSES];
  logic [32:0]      num     [NUM_CLASSES];
  logic [SUM_W:0]   trial;
  logic [SUM_W-1:0] r_t;
  logic [QUO_W-1:0] l_t;
  logic [QUO_W-1:0] q_t;

  always_comb begin
    sum_nxt[0] = '0;
    for (int i = 0; i < NUM_CLASSES; i++) sum_nxt[0] = sum_nxt[0] + SUM_W'(e_in[i]);
    // quotient stays below 2^17, so the top dividend bits start as remainder
    for (int i = 0; i < NUM_CLASSES; i++) begin
      num[i]        = {e_in[i], 16'h0000} + 33'(sum_nxt[0] >> 1);
      rem_nxt[0][i] = SUM_W'(num[i][32:QUO_W]);
      lo_nxt[0][i]  = num[i][QUO_W-1:0];
      q_nxt[0][i]   = '0;
    end
    trial = '0;
    r_t   = '0;
    l_t   = '0;
    q_t   = '0;
    for (int s = 1; s < NSTG; s++) begin
      sum_nxt[s] = sum_r[s-1];
      for (int i = 0; i < NUM_CLASSES; i++) begin
        r_t = rem_r[s-1][i];
        l_t = lo_r[s-1][i];
        q_t = q_r[s-1][i];
        for (int b = 0; b < DIV_PER; b++) begin
          if ((s - 1) * DIV_PER + b < QUO_W) begin
            trial = {r_t, l_t[QUO_W-1]};
            l_t   = {l_t[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, sum_r[s-1]}) begin
              r_t = SUM_W'(trial - {1'b0, sum_r[s-1]});
              q_t = {q_t[QUO_W-2:0], 1'b1};
            end else begin
              r_t = trial[SUM_W-1:0];
              q_t = {q_t[QUO_W-2:0], 1'b0};
            end
          end
        end
        rem_nxt[s][i] = r_t;
        lo_nxt[s][i]  = l_t;
        q_nxt[s][i]   = q_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
      for (int s = 1; s < NSTG; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      green_r[0] <= green_in;
      for (int s = 1; s < NSTG; s++) green_r[s] <= green_r[s-1];
      sum_r <= sum_nxt;
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      q_r   <= q_nxt;
    end
  end

  // quotient tops out at 65536, saturate to Q0.16
  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      prob_out[i] = q_r[NSTG-1][i][16] ? 16'hFFFF : q_r[NSTG-1][i][15:0];
    end
  end

  assign vld_out   = vld_r[NSTG-1];
  assign green_out = green_r[NSTG-1];

endmodule

[rtl/smx_ent.sv]
// ----------------------------------------------------------------------------
// smx_ent
// Argmax, base-2 log of each probability by repeated squaring, entropy
// accumulation and threshold checks.
// ----------------------------------------------------------------------------
module smx_ent (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_in,
  input  smx_pkg::q16_t             prob_in [smx_pkg::NUM_CLASSES],
  input  smx_pkg::q16_t             green_in,
  input  smx_pkg::thr_t             thr,
  output logic                      vld_out,
  output logic [smx_pkg::CLS_W-1:0] class_index,
  output logic                      valid_res,
  output smx_pkg::q16_t             confidence,
  output smx_pkg::q16_t             entropy_bits,
  output smx_pkg::q16_t             prob_out [smx_pkg::NUM_CLASSES]
);
  import smx_pkg::*;

  // argmax/normalise, squarings, products, sum, round and compare
  localparam int NSTG  = LOG_STEPS + 4;
  localparam int ST_TM = LOG_STEPS + 1;
  localparam int ST_SM = LOG_STEPS + 2;
  localparam int ENT_W = TSUM_W + 1 - 18;

  logic              vld_r   [NSTG];
  q16_t              green_r [NSTG];
  q16_t              prob_r  [NSTG][NUM_CLASSES];
  logic [CLS_W-1:0]  best_r  [NSTG];
  q16_t              conf_r  [NSTG];
  logic [CLS_W-1:0]  best_nxt;
  q16_t              conf_nxt;
  logic [3:0]        k_r     [LOG_STEPS+1][NUM_CLASSES];
  logic [3:0]        k_nxt   [LOG_STEPS+1][NUM_CLASSES];
  logic [15:0]       x_r     [LOG_STEPS+1][NUM_CLASSES];
  logic [15:0]       x_nxt   [LOG_STEPS+1][NUM_CLASSES];
  logic [15:0]       frac_r  [LOG_STEPS+1][NUM_CLASSES];
  logic [15:0]       frac_nxt[LOG_STEPS+1][NUM_CLASSES];
  logic [31:0]       sq      [LOG_STEPS][NUM_CLASSES];
  logic [20:0]       nl      [NUM_CLASSES];
  logic [TERM_W-1:0] term_r  [NUM_CLASSES];
  logic [TERM_W-1:0] term_nxt[NUM_CLASSES];
  logic [TSUM_W-1:0] tsum_r;
  logic [TSUM_W-1:0] tsum_nxt;
  logic [TSUM_W:0]   rnd;
  logic [ENT_W-1:0]  ent;
  q16_t              hb_nxt;
  q16_t              hb_r;
  logic              vres_r;
  logic              vres_nxt;

  always_comb begin
    // first index wins on ties
    best_nxt = '0;
    conf_nxt = prob_in[0];
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (prob_in[i] > conf_nxt) begin
        best_nxt = CLS_W'(i);
        conf_nxt = prob_in[i];
      end
    end

    // normalise to Q1.15 in [1,2)
    for (int i = 0; i < NUM_CLASSES; i++) begin
      k_nxt[0][i] = '0;
      for (int b = 0; b < 16; b++) begin
        if (prob_in[i][b]) k_nxt[0][i] = 4'(b);
      end
      x_nxt[0][i]    = prob_in[i] << (4'd15 - k_nxt[0][i]);
      frac_nxt[0][i] = '0;
    end

    for (int j = 1; j <= LOG_STEPS; j++) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        sq[j-1][i]     = 32'(x_r[j-1][i]) * 32'(x_r[j-1][i]);
        frac_nxt[j][i] = {frac_r[j-1][i][14:0], sq[j-1][i][31]};
        x_nxt[j][i]    = sq[j-1][i][31] ? sq[j-1][i][31:16] : sq[j-1][i][30:15];
        k_nxt[j][i]    = k_r[j-1][i];
      end
    end

    // zero probabilities add nothing
    for (int i = 0; i < NUM_CLASSES; i++) begin
      nl[i]       = 21'h100000 - {1'b0, k_r[LOG_STEPS][i], frac_r[LOG_STEPS][i]};
      term_nxt[i] = (prob_r[LOG_STEPS][i] == '0) ? '0
                  : TERM_W'(prob_r[LOG_STEPS][i]) * TERM_W'(nl[i]);
    end

    tsum_nxt = '0;
    for (int i = 0; i < NUM_CLASSES; i++) tsum_nxt = tsum_nxt + TSUM_W'(term_r[i]);

    rnd      = {1'b0, tsum_r} + (TSUM_W+1)'(1 << 17);
    ent      = rnd[TSUM_W:18];
    hb_nxt   = (ent > ENT_W'(16'hFFFF)) ? 16'hFFFF : ent[15:0];
    vres_nxt = (green_r[ST_SM] >= thr.min_green) && (hb_nxt <= thr.max_entropy) &&
               (conf_r[ST_SM] >= thr.min_conf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
      for (int s = 1; s < NSTG; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      green_r[0] <= green_in;
      prob_r[0]  <= prob_in;
      best_r[0]  <= best_nxt;
      conf_r[0]  <= conf_nxt;
      for (int s = 1; s < NSTG; s++) begin
        green_r[s] <= green_r[s-1];
        prob_r[s]  <= prob_r[s-1];
        best_r[s]  <= best_r[s-1];
        conf_r[s]  <= conf_r[s-1];
      end
      k_r    <= k_nxt;
      x_r    <= x_nxt;
      frac_r <= frac_nxt;
      term_r <= term_nxt;
      tsum_r <= tsum_nxt;
      hb_r   <= hb_nxt;
      vres_r <= vres_nxt;
    end
  end

  assign vld_out      = vld_r[NSTG-1];
  assign class_index  = best_r[NSTG-1];
  assign valid_res    = vres_r;
  assign confidence   = conf_r[NSTG-1];
  assign entropy_bits = hb_r;
  assign prob_out     = prob_r[NSTG-1];

endmodule

[rtl/softmax_entropy_ood_classifier.sv]
// throughput: one transaction per cycle while no held result stalls the pipeline;
// the exponent, division and log2 squaring chains are fully pipelined,
// one multiply or a few quotient bits per stage
// a stalled output freezes the whole pipeline and raises in_stall
// reset clears all pipeline valid bits and loads the threshold defaults
// ----------------------------------------------------------------------------
// softmax_entropy_ood_classifier
// Softmax over four logits with argmax, confidence, entropy and a
// plausibility flag against three programmable thresholds.
// ----------------------------------------------------------------------------
module softmax_entropy_ood_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_logit_0,
  input  logic signed [15:0]  in_logit_1,
  input  logic signed [15:0]  in_logit_2,
  input  logic signed [15:0]  in_logit_3,
  input  logic [15:0]         in_green_ratio,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_class_index,
  output logic                out_valid_res,
  output logic [15:0]         out_confidence,
  output logic [15:0]         out_entropy_bits,
  output logic [15:0]         out_prob_0,
  output logic [15:0]         out_prob_1,
  output logic [15:0]         out_prob_2,
  output logic [15:0]         out_prob_3,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import smx_pkg::*;

  logic   en;
  thr_t   thr_r;
  logit_t logits   [NUM_CLASSES];
  logic   exp_vld;
  exp_t   exp_val  [NUM_CLASSES];
  q16_t   exp_green;
  logic   div_vld;
  q16_t   div_prob [NUM_CLASSES];
  q16_t   div_green;
  q16_t   probs    [NUM_CLASSES];

  // whole pipeline advances unless a result is held back
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  assign logits[0] = in_logit_0;
  assign logits[1] = in_logit_1;
  assign logits[2] = in_logit_2;
  assign logits[3] = in_logit_3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.min_green   <= MIN_GREEN_RST;
      thr_r.max_entropy <= MAX_ENTROPY_RST;
      thr_r.min_conf    <= MIN_CONF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_GREEN:   thr_r.min_green   <= cfg_data;
        CFG_MAX_ENTROPY: thr_r.max_entropy <= cfg_data;
        CFG_MIN_CONF:    thr_r.min_conf    <= cfg_data;
        default: ;
      endcase
    end
  end

  smx_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (in_valid),
    .logit     (logits),
    .green_in  (in_green_ratio),
    .vld_out   (exp_vld),
    .e_out     (exp_val),
    .green_out (exp_green)
  );

  smx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_in    (exp_vld),
    .e_in      (exp_val),
    .green_in  (exp_green),
    .vld_out   (div_vld),
    .prob_out  (div_prob),
    .green_out (div_green)
  );

  smx_ent u_ent (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .vld_in       (div_vld),
    .prob_in      (div_prob),
    .green_in     (div_green),
    .thr          (thr_r),
    .vld_out      (out_valid),
    .class_index  (out_class_index),
    .valid_res    (out_valid_res),
    .confidence   (out_confidence),
    .entropy_bits (out_entropy_bits),
    .prob_out     (probs)
  );

  assign out_prob_0 = probs[0];
  assign out_prob_1 = probs[1];
  assign out_prob_2 = probs[2];
  assign out_prob_3 = probs[3];

endmodule

[rtl/smx_chk.sv]
// ----------------------------------------------------------------------------
// smx_chk
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module smx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_class_index,
  input logic        out_valid_res,
  input logic [15:0] out_confidence,
  input logic [15:0] out_entropy_bits,
  input logic [15:0] out_prob_0,
  input logic [15:0] out_prob_1,
  input logic [15:0] out_prob_2,
  input logic [15:0] out_prob_3
);

  // held result transaction keeps its class, confidence, entropy and flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_confidence) &&
    $stable(out_class_index) && $stable(out_entropy_bits) && $stable(out_valid_res))
    else $error("stalled result changed");

  // a held result backs up to the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output held");

  a_conf_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_confidence >= out_prob_0 && out_confidence >= out_prob_1 &&
    out_confidence >= out_prob_2 && out_confidence >= out_prob_3)
    else $error("confidence below a class probability");

  a_index_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_class_index == 2'd0 && out_confidence == out_prob_0) ||
    (out_class_index == 2'd1 && out_confidence == out_prob_1) ||
    (out_class_index == 2'd2 && out_confidence == out_prob_2) ||
    (out_class_index == 2'd3 && out_confidence == out_prob_3))
    else $error("class index does not point at confidence");

endmodule

bind softmax_entropy_ood_classifier smx_chk u_smx_chk (.*);
